// ===== sv/sllr_pkg.sv =====
// ============================================================================
// sllr_pkg
// Shared types and constants of the sliding-log rate limiter: register map,
// item modes, register reset values and the result item layout.
// ============================================================================
`default_nettype none

package sllr_pkg;

    localparam int CNT_W      = 5;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_SLOTS  = 31;

    localparam int OUT_DEPTH  = 4;
    localparam int OUT_AW     = 2;
    localparam int OUT_CW     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_COUNT = 2'd0,
        REG_HIT_SPACING  = 2'd1,
        REG_EXPIRY_DELAY = 2'd2
    } cfg_reg_t;

    localparam logic MODE_HIT   = 1'b0;
    localparam logic MODE_PROBE = 1'b1;

    localparam logic [CNT_W-1:0] WINDOW_COUNT_RST = 5'd10;
    localparam logic [CFG_W-1:0] HIT_SPACING_RST  = 32'd1000;
    localparam logic [CFG_W-1:0] EXPIRY_DELAY_RST = 32'd60000;

    typedef struct packed {
        logic allowed;
        logic expired;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/sllr_store.sv =====
// ============================================================================
// sllr_store
// Ring of hit times: two copies written together, three registered read ports
// (oldest slot, latest slot, last slot of the window).
// ============================================================================
`default_nettype none

module sllr_store #(
    parameter int SLOTS = 16,
    parameter int AW    = 4,
    parameter int TW    = 48
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [TW-1:0] wdata,
    input  wire logic [AW-1:0] ra,
    input  wire logic [AW-1:0] rb,
    input  wire logic [AW-1:0] rc,
    output logic      [TW-1:0] rd_a,
    output logic      [TW-1:0] rd_b,
    output logic      [TW-1:0] rd_c
);

    logic [TW-1:0] mem_ab [SLOTS];
    logic [TW-1:0] mem_c  [SLOTS];

    logic [TW-1:0] rd_a_reg;
    logic [TW-1:0] rd_b_reg;
    logic [TW-1:0] rd_c_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_ab[waddr] <= wdata;
            mem_c[waddr]  <= wdata;
        end
        rd_a_reg <= mem_ab[ra];
        rd_b_reg <= mem_ab[rb];
        rd_c_reg <= mem_c[rc];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;
    assign rd_c = rd_c_reg;

endmodule

`default_nettype wire

// ===== sv/sllr_out_fifo.sv =====
// ============================================================================
// sllr_out_fifo
// Four-entry result queue between the decision stage and the output channel.
// ============================================================================
`default_nettype none

module sllr_out_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire sllr_pkg::result_t             push_item,
    output logic [sllr_pkg::OUT_CW-1:0]        count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               allowed,
    output logic                               expired
);

    import sllr_pkg::*;

    result_t               entry_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]     wr_ptr_reg;
    logic [OUT_AW-1:0]     wr_ptr_next;
    logic [OUT_AW-1:0]     rd_ptr_reg;
    logic [OUT_AW-1:0]     rd_ptr_next;
    logic [OUT_CW-1:0]     count_reg;
    logic [OUT_CW-1:0]     count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OUT_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OUT_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + OUT_CW'(push) - OUT_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign count   = count_reg;
    assign allowed = entry_reg[rd_ptr_reg].allowed;
    assign expired = entry_reg[rd_ptr_reg].expired;

endmodule

`default_nettype wire

// ===== sv/sliding_log_rate_limiter_core.sv =====
// ============================================================================
// sliding_log_rate_limiter_core
// Sliding-log rate limiter over a ring of recent hit times.
//
// Input channel in_valid/in_ready carries one item: mode (hit or probe) and
// timestamp. Output channel out_valid/out_ready returns one result per item:
// allowed and expired. Registers are written through cfg_wr_en, cfg_index
// and cfg_wdata; the user must write them only while no item is in flight,
// which the block does not enforce. An item accepted at a clock edge is
// decided in the following cycle and then offered from the result queue.
// One item per cycle is sustained while the queue has room; the loop that
// sets this is the write-slot update, which feeds the next item's ring
// read address in the same cycle it is decided. Every item reads the ring
// through three ports; a hit attempt that is not refused writes one slot.
// Reset clears the slot valid bits, the write slot, the hit flag, the
// result queue and restores register defaults; no clearing pass is needed.
// Results wait in a four-entry queue when the receiver stalls; in_ready
// drops once four items are held in the decision stage and queue together.
// ============================================================================
`default_nettype none

module sliding_log_rate_limiter_core #(
    parameter int DEPTH      = 16,
    parameter int TIME_WIDTH = 48
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sllr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sllr_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic [TIME_WIDTH-1:0]             timestamp,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   allowed,
    output logic                                   expired
);

    import sllr_pkg::*;

    localparam int SLOTS = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    // configuration
    logic [CNT_W-1:0]      window_count_reg;
    logic [CNT_W-1:0]      window_count_next;
    logic [CFG_W-1:0]      hit_spacing_reg;
    logic [CFG_W-1:0]      hit_spacing_next;
    logic [CFG_W-1:0]      expiry_delay_reg;
    logic [CFG_W-1:0]      expiry_delay_next;

    // ring control
    logic [SLOTS-1:0]      slot_valid_reg;
    logic [SLOTS-1:0]      slot_valid_next;
    logic [AW-1:0]         ws_reg;
    logic [AW-1:0]         ws_next;
    logic                  hit_seen_reg;
    logic                  hit_seen_next;

    // decision stage
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_mode_reg;
    logic [TIME_WIDTH-1:0] s1_now_reg;
    logic [AW-1:0]         s1_ws_reg;
    logic [AW-1:0]         s1_pb_reg;

    // last ring write, for forwarding
    logic                  wr_v_reg;
    logic                  wr_v_next;
    logic [AW-1:0]         wr_addr_reg;
    logic [TIME_WIDTH-1:0] wr_data_reg;

    logic [CNT_W-1:0]      slots_used;
    logic [CNT_W-1:0]      last_idx;
    logic [AW-1:0]         last_slot;
    logic                  in_fire;
    logic [AW-1:0]         rd_b_addr;
    logic [TIME_WIDTH-1:0] rd_a;
    logic [TIME_WIDTH-1:0] rd_b;
    logic [TIME_WIDTH-1:0] rd_c;
    logic [TIME_WIDTH-1:0] time_a;
    logic [TIME_WIDTH-1:0] time_b;
    logic [TIME_WIDTH-1:0] time_c;
    logic [TIME_WIDTH-1:0] diff_a;
    logic [TIME_WIDTH-1:0] diff_l;
    logic [TIME_WIDTH-1:0] lat_time;
    logic [AW-1:0]         lat_addr;
    logic                  lat_is_now;
    logic                  lat_valid;
    logic                  refuse;
    logic                  hit;
    logic [CNT_W-1:0]      ws_cnt;
    logic                  ws_wrap;
    logic                  ws_beyond;
    logic [AW-1:0]         ws_adv;
    logic                  expired_res;
    result_t               result;
    logic [OUT_CW-1:0]     fifo_count;
    logic [OUT_CW-1:0]     in_flight;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_comb
    begin
        window_count_next = window_count_reg;
        hit_spacing_next  = hit_spacing_reg;
        expiry_delay_next = expiry_delay_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_COUNT: window_count_next = cfg_wdata[CNT_W-1:0];
                REG_HIT_SPACING:  hit_spacing_next  = cfg_wdata;
                REG_EXPIRY_DELAY: expiry_delay_next = cfg_wdata;
                default:          window_count_next = window_count_reg;
            endcase
        end
    end

    always_comb
    begin
        if (window_count_reg == '0)
        begin
            slots_used = CNT_W'(1);
        end
        else if (window_count_reg > CNT_W'(SLOTS))
        begin
            slots_used = CNT_W'(SLOTS);
        end
        else
        begin
            slots_used = window_count_reg;
        end
    end

    assign last_idx  = slots_used - CNT_W'(1);
    assign last_slot = last_idx[AW-1:0];

    // ------------------------------------------------------------------
    // decision stage
    // ------------------------------------------------------------------
    always_comb
    begin
        time_a = (wr_v_reg && (wr_addr_reg == s1_ws_reg)) ? wr_data_reg : rd_a;
        time_b = (wr_v_reg && (wr_addr_reg == s1_pb_reg)) ? wr_data_reg : rd_b;
        time_c = (wr_v_reg && (wr_addr_reg == last_slot)) ? wr_data_reg : rd_c;

        diff_a = s1_now_reg - time_a;
        refuse = slot_valid_reg[s1_ws_reg] && (CW'(diff_a) < CW'(hit_spacing_reg));
        hit    = s1_valid_reg && (s1_mode_reg == MODE_HIT) && !refuse;

        ws_cnt    = CNT_W'(s1_ws_reg);
        ws_wrap   = (ws_cnt + CNT_W'(1)) >= slots_used;
        ws_beyond = ws_cnt >= slots_used;
        ws_adv    = ws_wrap ? '0 : s1_ws_reg + AW'(1);

        ws_next       = hit ? ws_adv : ws_reg;
        hit_seen_next = hit_seen_reg || hit;

        slot_valid_next = slot_valid_reg;
        if (hit)
        begin
            slot_valid_next[s1_ws_reg] = 1'b1;
        end

        lat_is_now = hit && !ws_beyond;
        lat_addr   = hit ? last_slot : s1_pb_reg;
        lat_time   = hit ? time_c : time_b;
        lat_valid  = slot_valid_reg[lat_addr];
        diff_l     = s1_now_reg - lat_time;

        expired_res = !hit_seen_next ||
                      (!lat_is_now &&
                       (!lat_valid || (CW'(diff_l) > CW'(expiry_delay_reg))));

        result.allowed = hit;
        result.expired = expired_res;

        wr_v_next = hit;
    end

    // ------------------------------------------------------------------
    // issue stage
    // ------------------------------------------------------------------
    assign in_flight = fifo_count + OUT_CW'(s1_valid_reg);
    assign in_ready  = in_flight < OUT_CW'(OUT_DEPTH);
    assign in_fire   = in_valid && in_ready;

    assign s1_valid_next = in_fire;
    assign rd_b_addr     = (ws_next == '0) ? last_slot : ws_next - AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg <= WINDOW_COUNT_RST;
            hit_spacing_reg  <= HIT_SPACING_RST;
            expiry_delay_reg <= EXPIRY_DELAY_RST;
            slot_valid_reg   <= '0;
            ws_reg           <= '0;
            hit_seen_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            wr_v_reg         <= 1'b0;
        end
        else
        begin
            window_count_reg <= window_count_next;
            hit_spacing_reg  <= hit_spacing_next;
            expiry_delay_reg <= expiry_delay_next;
            slot_valid_reg   <= slot_valid_next;
            ws_reg           <= ws_next;
            hit_seen_reg     <= hit_seen_next;
            s1_valid_reg     <= s1_valid_next;
            wr_v_reg         <= wr_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= mode;
        s1_now_reg  <= timestamp;
        s1_ws_reg   <= ws_next;
        s1_pb_reg   <= rd_b_addr;
        wr_addr_reg <= s1_ws_reg;
        wr_data_reg <= s1_now_reg;
    end

    sllr_store #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .TW    (TIME_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (hit),
        .waddr (s1_ws_reg),
        .wdata (s1_now_reg),
        .ra    (ws_next),
        .rb    (rd_b_addr),
        .rc    (last_slot),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .rd_c  (rd_c)
    );

    sllr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_item (result),
        .count     (fifo_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .allowed   (allowed),
        .expired   (expired)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_hit_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> slot_valid_reg[$past(s1_ws_reg)] && hit_seen_reg)
        else $error("hit did not mark its slot valid");

    a_hit_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (ws_reg == $past(ws_adv)) && wr_v_reg && (wr_addr_reg == $past(s1_ws_reg)))
        else $error("write slot or forward entry not updated after hit");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= OUT_CW'(OUT_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire
